/* design/hbk_pkg.sv */
// Shared types, constants and the key-code translation function for the
// boot keyboard to ASCII block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hbk_pkg;

    localparam int HBK_SLOTS   = 6;
    localparam int HBK_QDEPTH  = 4;
    localparam int HBK_QAW     = 2;

    localparam logic [7:0] HBK_SHIFT_MASK   = 8'h22;
    localparam logic [7:0] HBK_CAG_MASK     = 8'hdd;
    localparam logic [7:0] HBK_CAPS_KEY     = 8'h39;
    localparam logic [7:0] HBK_LETTER_FIRST = 8'h04;
    localparam logic [7:0] HBK_LETTER_LAST  = 8'h1d;
    localparam logic [7:0] HBK_TABLE_FIRST  = 8'h1e;
    localparam logic [7:0] HBK_TABLE_LAST   = 8'h38;
    localparam logic [7:0] HBK_ERR_LAST     = 8'h03;

    typedef logic [7:0] t_key;
    typedef logic [6:0] t_char;

    // One report's worth of characters, one per slot, with a mask of slots
    // that produce a character.
    typedef struct packed {
        logic  [HBK_SLOTS-1:0]        mask;
        logic  [HBK_SLOTS-1:0][6:0]   chars;
    } t_hbk_entry;

    // Usage 0x1e..0x38, padded to 32; zero means no character.
    localparam t_char HBK_PLAIN_TAB [32] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h0d, 7'h1b, 7'h08, 7'h09, 7'h20,
        7'h2d, 7'h3d, 7'h5b, 7'h5d, 7'h5c, 7'h00, 7'h3b, 7'h27, 7'h60, 7'h2c,
        7'h2e, 7'h2f,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };
    localparam t_char HBK_SHIFT_TAB [32] = '{
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
        7'h0d, 7'h1b, 7'h08, 7'h09, 7'h20,
        7'h5f, 7'h2b, 7'h7b, 7'h7d, 7'h7c, 7'h00, 7'h3a, 7'h22, 7'h7e, 7'h3c,
        7'h3e, 7'h3f,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Translate one usage code; zero means the code gives no character.
    function automatic t_char hbk_code_to_char(input t_key code, input logic shifted,
                                               input logic caps);
        t_key  rel;
        t_char ch;
        rel = code - HBK_TABLE_FIRST;
        ch  = 7'h00;
        if (code >= HBK_LETTER_FIRST && code <= HBK_LETTER_LAST) begin
            ch = ((shifted ^ caps) ? 7'h41 : 7'h61) + (code[6:0] - HBK_LETTER_FIRST[6:0]);
        end else if (code >= HBK_TABLE_FIRST && code <= HBK_TABLE_LAST) begin
            ch = shifted ? HBK_SHIFT_TAB[rel[4:0]] : HBK_PLAIN_TAB[rel[4:0]];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

/* design/hbk_front.sv */
// Front end: accepts reports, tracks held keys and caps lock, and turns each report with new
// characters, no error code and no ctrl/alt/gui into one entry of per-slot characters. Uses hbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbk_front
    import hbk_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_modifiers,
    input  wire logic [HBK_SLOTS-1:0][7:0]     i_slots,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output t_hbk_entry                         o_q_entry
);

    logic [HBK_SLOTS-1:0][7:0] r_prior;
    logic [HBK_SLOTS-1:0][7:0] n_prior;
    logic                      r_caps;
    logic                      n_caps;

    logic                      accept;
    logic                      is_err;
    logic                      is_cag;
    logic                      shifted;
    logic                      caps_run;
    logic [HBK_SLOTS-1:0]      new_key;
    logic [HBK_SLOTS-1:0]      caps_at;
    t_hbk_entry                entry;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_cag  = (i_modifiers & HBK_CAG_MASK) != 8'h00;
    assign shifted = (i_modifiers & HBK_SHIFT_MASK) != 8'h00;

    // Classify slots: error codes, new presses, caps state seen by each slot
    always_comb begin
        is_err   = 1'b0;
        caps_run = r_caps;
        new_key  = '0;
        caps_at  = '0;
        entry    = '0;
        for (int k = 0; k < HBK_SLOTS; k++) begin
            if (i_slots[k] != 8'h00 && i_slots[k] <= HBK_ERR_LAST) begin
                is_err = 1'b1;
            end
            new_key[k] = i_slots[k] != 8'h00;
            for (int j = 0; j < HBK_SLOTS; j++) begin
                if (r_prior[j] == i_slots[k]) begin
                    new_key[k] = 1'b0;
                end
            end
            caps_at[k] = caps_run;
            if (new_key[k] && i_slots[k] == HBK_CAPS_KEY) begin
                caps_run = !caps_run;
            end
            entry.chars[k] = hbk_code_to_char(i_slots[k], shifted, caps_at[k]);
            entry.mask[k]  = new_key[k] && (entry.chars[k] != 7'h00);
        end
    end

    // Update held keys and caps lock; drop reports carrying error codes
    always_comb begin
        n_prior = r_prior;
        n_caps  = r_caps;
        if (accept && !is_err) begin
            n_prior = i_slots;
            if (!is_cag) begin
                n_caps = caps_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior <= '0;
            r_caps  <= 1'b0;
        end else begin
            r_prior <= n_prior;
            r_caps  <= n_caps;
        end
    end

    assign o_q_push  = accept && !is_err && !is_cag && (entry.mask != '0);
    assign o_q_entry = entry;

endmodule

`default_nettype wire

/* design/hbk_fifo.sv */
// Short queue of report entries between front and back end.
// Uses hbk_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module hbk_fifo
    import hbk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  t_hbk_entry       i_entry,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_valid,
    output t_hbk_entry       o_entry
);

    t_hbk_entry             r_mem [HBK_QDEPTH];
    logic [HBK_QAW-1:0]     r_wr_ptr;
    logic [HBK_QAW-1:0]     r_rd_ptr;
    logic [HBK_QAW:0]       r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = r_count == HBK_QAW'(0) + (HBK_QAW+1)'(HBK_QDEPTH);
    assign o_valid = r_count != '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_entry = r_mem[r_rd_ptr];

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/hbk_back.sv */
// Back end: holds one report entry and emits its characters one beat at a
// time in slot order, flagging the last. Uses hbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hbk_back
    import hbk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  t_hbk_entry       i_q_entry,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_ascii_char,
    output logic             o_last_of_report
);

    logic [HBK_SLOTS-1:0]      r_mask;
    logic [HBK_SLOTS-1:0][6:0] r_chars;
    logic [HBK_SLOTS-1:0]      pick;
    logic [HBK_SLOTS-1:0]      rest;
    logic                      fire;
    logic                      load;

    assign pick    = r_mask & (~r_mask + HBK_SLOTS'(1));
    assign rest    = r_mask & ~pick;
    assign o_valid = r_mask != '0;
    assign fire    = o_valid && i_ready;
    assign o_last_of_report = rest == '0;
    assign load    = !o_valid || (fire && o_last_of_report);
    assign o_q_pop = load && i_q_valid;

    // Select the character of the lowest pending slot
    always_comb begin
        o_ascii_char = '0;
        for (int k = 0; k < HBK_SLOTS; k++) begin
            if (pick[k]) begin
                o_ascii_char = o_ascii_char | r_chars[k];
            end
        end
    end

    // Retire the sent slot; load the next entry when this one is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (o_q_pop) begin
            r_mask <= i_q_entry.mask;
        end else if (fire) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_chars <= i_q_entry.chars;
        end
    end

endmodule

`default_nettype wire

/* design/hid_boot_keyboard_to_ascii_core.sv */
// Top level of the boot keyboard report to ASCII translator: front end,
// entry queue and back end. Uses hbk_pkg, hbk_front, hbk_fifo, hbk_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   report  | in        | i_valid / o_ready  | i_modifiers, i_key_slot_0..5
//   char    | out       | o_valid / i_ready  | o_ascii_char, o_last_of_report
//
// A report is taken whenever the queue has room; held keys and
// caps lock update at the edge that takes it, so reports may arrive back to back.
// The back end sends one character per cycle while i_ready is high, and a
// report yields at most six characters. The first passes through the queue
// and then the back-end registers before it can leave. The four-entry queue
// lets the input keep flowing while the output stalls. Reset is synchronous,
// active low, and clears held keys, caps lock, queue and back end.
`timescale 1ns / 1ps
`default_nettype none

module hid_boot_keyboard_to_ascii_core
    import hbk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_modifiers,
    input  wire logic [7:0]  i_key_slot_0,
    input  wire logic [7:0]  i_key_slot_1,
    input  wire logic [7:0]  i_key_slot_2,
    input  wire logic [7:0]  i_key_slot_3,
    input  wire logic [7:0]  i_key_slot_4,
    input  wire logic [7:0]  i_key_slot_5,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [6:0]       o_ascii_char,
    output logic             o_last_of_report
);

    logic [HBK_SLOTS-1:0][7:0] slots;
    logic                      q_push;
    logic                      q_full;
    logic                      q_pop;
    logic                      q_valid;
    t_hbk_entry                q_in;
    t_hbk_entry                q_out;

    assign slots = {i_key_slot_5, i_key_slot_4, i_key_slot_3,
                    i_key_slot_2, i_key_slot_1, i_key_slot_0};

    hbk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_modifiers (i_modifiers),
        .i_slots     (slots),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_entry   (q_in)
    );

    hbk_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    hbk_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_entry        (q_out),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_ascii_char     (o_ascii_char),
        .o_last_of_report (o_last_of_report)
    );

    // Queue writes only come from accepted reports and never overflow
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (i_valid && o_ready && !q_full))
        else $error("queue push without accepted report or while full");

    // Back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // Every emitted beat carries a real character
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char != 7'h00))
        else $error("null character emitted");

    // Only entries with characters enter the queue
    a_entry_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_in.mask != '0))
        else $error("empty entry queued");

endmodule

`default_nettype wire
